@@ hdl/wedt_pkg.sv @@
// ----------------------------------------------------------------------------
// Wireframe edge dedup table package
// Types, sizes and compare functions shared by the edge dedup table.
// ----------------------------------------------------------------------------
`default_nettype none

package wedt_pkg;

	// Table sizes.
	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 1024;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int EIDX_W       = $clog2(MAX_EDGES);
	localparam int CNT_W        = 11;
	localparam int COORD_W      = 32;

	localparam logic [CNT_W-1:0] VTX_FULL  = CNT_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0] EDGE_FULL = CNT_W'(MAX_EDGES);

	// Single precision field masks.
	localparam logic [COORD_W-1:0] MAG_MASK  = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] EXP_MASK  = 32'h7F80_0000;
	localparam logic [COORD_W-1:0] FRAC_MASK = 32'h007F_FFFF;

	// One input beat: an edge given as two points.
	typedef struct packed {
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] first_z;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic [COORD_W-1:0] second_z;
	} wedt_in_t;

	// One result beat.
	typedef struct packed {
		logic [9:0]       low_vertex_index;
		logic [9:0]       high_vertex_index;
		logic             edge_was_new;
		logic [CNT_W-1:0] edge_total;
		logic [CNT_W-1:0] vertex_total;
		logic             overflow;
	} wedt_out_t;

	// One stored vertex.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} wedt_point_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VTX_A,
		ST_VTX_B,
		ST_EDGE,
		ST_REPORT
	} wedt_state_t;

	// Coordinate equality: both zeros match, a NaN matches nothing.
	function automatic logic coord_eq(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic a_nan;
		logic b_nan;
		a_nan = ((a & EXP_MASK) == EXP_MASK) && ((a & FRAC_MASK) != '0);
		b_nan = ((b & EXP_MASK) == EXP_MASK) && ((b & FRAC_MASK) != '0);
		if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0)) begin
			return 1'b1;
		end
		return !a_nan && !b_nan && (a == b);
	endfunction

	// Point equality over all three coordinates.
	function automatic logic point_eq(input wedt_point_t a, input wedt_point_t b);
		return coord_eq(a.x, b.x) && coord_eq(a.y, b.y) && coord_eq(a.z, b.z);
	endfunction

endpackage

`default_nettype wire

@@ hdl/wireframe_edge_dedup_table.sv @@
// ----------------------------------------------------------------------------
// Wireframe edge dedup table
// Looks up both points of an edge in a vertex table, appends new points,
// then looks up the ordered index pair in an edge table and appends it when new.
// ----------------------------------------------------------------------------
// An edge is taken when start is high and busy is low; busy then stays high
// until the result beat, which is shown for exactly one cycle with done high
// and must be captured then. Each of the three scans (first point, second
// point, edge pair) reads its table one entry at a time, up to a match or
// the last filled entry, and appends the point or pair when it ends without
// a match and the table has room; a new point that finds the vertex table
// full ends the work early and skips the scans left. The scan walks the
// single read port of each table one entry per cycle through one registered
// compare stage. No clearing pass follows reset.
`default_nettype none

module wireframe_edge_dedup_table (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire wedt_pkg::wedt_in_t   item,
	output logic                      done,
	output wedt_pkg::wedt_out_t       result
);

	import wedt_pkg::*;

	// Tables.
	wedt_point_t              vmem [MAX_VERTICES];
	logic [2*VIDX_W-1:0]      emem [MAX_EDGES];

	// Control state.
	wedt_state_t              state_q;
	wedt_state_t              state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         vcount_q;
	logic [CNT_W-1:0]         ecount_q;
	logic                     rv_s1;

	// Payload registers.
	wedt_in_t                 item_q;
	wedt_point_t              vrd_s1;
	logic [2*VIDX_W-1:0]      erd_s1;
	logic [CNT_W-1:0]         ra_s1;
	logic [VIDX_W-1:0]        a_q;
	logic [VIDX_W-1:0]        lo_q;
	logic [VIDX_W-1:0]        hi_q;
	logic                     new_q;
	logic                     ovf_q;

	// Sequencer controls.
	logic                     accept;
	logic                     vtx_phase;
	logic                     scan_phase;
	logic [CNT_W-1:0]         count_sel;
	wedt_point_t              cur_point;
	logic                     hit;
	logic                     miss;
	logic                     issue;
	logic                     finish;
	logic                     vfull;
	logic                     efull;
	logic [VIDX_W-1:0]        found_idx;

	// Point under lookup and the scan limit of the current phase.
	always_comb begin
		cur_point  = (state_q == ST_VTX_A) ?
			wedt_point_t'{x: item_q.first_x, y: item_q.first_y, z: item_q.first_z} :
			wedt_point_t'{x: item_q.second_x, y: item_q.second_y, z: item_q.second_z};
		vtx_phase  = (state_q == ST_VTX_A) || (state_q == ST_VTX_B);
		scan_phase = vtx_phase || (state_q == ST_EDGE);
		count_sel  = vtx_phase ? vcount_q : ecount_q;
		vfull      = (vcount_q >= VTX_FULL);
		efull      = (ecount_q >= EDGE_FULL);
		accept     = start && (state_q == ST_IDLE);
	end

	// Shared compare stage on the registered read data.
	always_comb begin
		if (vtx_phase) begin
			hit = rv_s1 && point_eq(cur_point, vrd_s1);
		end else begin
			hit = rv_s1 && (erd_s1 == {lo_q, hi_q});
		end
		miss      = scan_phase && !rv_s1 && (cnt_q >= count_sel);
		issue     = scan_phase && (cnt_q < count_sel) && !hit;
		finish    = hit || miss;
		found_idx = hit ? ra_s1[VIDX_W-1:0] : vcount_q[VIDX_W-1:0];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_VTX_A;
				end
			end
			ST_VTX_A: begin
				if (finish) begin
					state_d = (miss && vfull) ? ST_REPORT : ST_VTX_B;
				end
			end
			ST_VTX_B: begin
				if (finish) begin
					state_d = (miss && vfull) ? ST_REPORT : ST_EDGE;
				end
			end
			ST_EDGE: begin
				if (finish) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Scan counter, read valid and table counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rv_s1    <= 1'b0;
			vcount_q <= '0;
			ecount_q <= '0;
		end else begin
			rv_s1 <= issue;
			if (accept || finish) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (vtx_phase && miss && !vfull) begin
				vcount_q <= vcount_q + 1'b1;
			end
			if ((state_q == ST_EDGE) && miss && !efull) begin
				ecount_q <= ecount_q + 1'b1;
			end
		end
	end

	// Result fields and the latched item.
	always_ff @(posedge clk) begin
		ra_s1 <= cnt_q;
		if (accept) begin
			item_q <= item;
			lo_q   <= '0;
			hi_q   <= '0;
			new_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end
		if (vtx_phase && finish) begin
			if (miss && vfull) begin
				ovf_q <= 1'b1;
			end else if (state_q == ST_VTX_A) begin
				a_q <= found_idx;
			end else begin
				lo_q <= (a_q < found_idx) ? a_q : found_idx;
				hi_q <= (a_q < found_idx) ? found_idx : a_q;
			end
		end
		if ((state_q == ST_EDGE) && miss) begin
			if (efull) begin
				ovf_q <= 1'b1;
			end else begin
				new_q <= 1'b1;
			end
		end
	end

	// Vertex table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (vtx_phase && miss && !vfull) begin
			vmem[vcount_q[VIDX_W-1:0]] <= cur_point;
		end
		vrd_s1 <= vmem[cnt_q[VIDX_W-1:0]];
	end

	// Edge table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EDGE) && miss && !efull) begin
			emem[ecount_q[EIDX_W-1:0]] <= {lo_q, hi_q};
		end
		erd_s1 <= emem[cnt_q[EIDX_W-1:0]];
	end

	// Result beat.
	always_comb begin
		result.low_vertex_index  = lo_q;
		result.high_vertex_index = hi_q;
		result.edge_was_new      = new_q;
		result.edge_total        = ecount_q;
		result.vertex_total      = vcount_q;
		result.overflow          = ovf_q;
	end

	// The counts never pass the table sizes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vcount_q <= VTX_FULL) && (ecount_q <= EDGE_FULL))
		else $error("table count beyond table size");

	// The tables only change while an item is being worked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(vcount_q) && $stable(ecount_q))
		else $error("table count changed while idle");

	// A read in flight belongs to a scan that is still running.
	assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_VTX_A) || (state_q == ST_VTX_B) ||
			(state_q == ST_EDGE))
		else $error("read data outside a scan");

	// A dropped insert never reports a new edge, and every result pair is ordered.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(ovf_q && new_q) && (lo_q <= hi_q))
		else $error("inconsistent result beat");

	// The result beat lasts one cycle and the block is free after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result beat longer than one cycle");

endmodule

`default_nettype wire

@@ test/wireframe_edge_dedup_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wireframe edge dedup table checker
// Watches the edge and result channels, keeps its own vertex and edge
// tables, and compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------

module wireframe_edge_dedup_table_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire wedt_pkg::wedt_in_t  item,
	input  wire logic                done,
	input  wire wedt_pkg::wedt_out_t result,
	output int                       fail_count,
	output int                       pending,
	output int                       vertices_held,
	output int                       edges_held
);

	import wedt_pkg::*;

	// Shadow tables, filled in the same order as the block fills its own.
	logic [COORD_W-1:0] vtx_x [MAX_VERTICES];
	logic [COORD_W-1:0] vtx_y [MAX_VERTICES];
	logic [COORD_W-1:0] vtx_z [MAX_VERTICES];
	logic [VIDX_W-1:0]  edge_lo [MAX_EDGES];
	logic [VIDX_W-1:0]  edge_hi [MAX_EDGES];
	int                 vtx_count;
	int                 edge_count;

	// Results still owed by the block, oldest first.
	wedt_out_t          owed_results[$];
	int                 beat_no;

	// A NaN has an all-ones exponent and a nonzero fraction.
	function automatic bit is_nan(input logic [COORD_W-1:0] c);
		return (c[30:23] == 8'hFF) && (c[22:0] != '0);
	endfunction

	// Both signed zeros are equal; a NaN is equal to nothing.
	function automatic bit coords_match(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		if ((a[30:0] == '0) && (b[30:0] == '0)) begin
			return 1'b1;
		end
		if (is_nan(a) || is_nan(b)) begin
			return 1'b0;
		end
		return a == b;
	endfunction

	// Finds a point, or appends it when there is room left.
	task automatic find_or_add_vertex(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
			output bit placed, output int idx);
		placed = 1'b0;
		idx = 0;
		for (int i = 0; i < vtx_count && !placed; i++) begin
			if (coords_match(x, vtx_x[i]) && coords_match(y, vtx_y[i]) &&
					coords_match(z, vtx_z[i])) begin
				placed = 1'b1;
				idx = i;
			end
		end
		if (!placed && vtx_count < MAX_VERTICES) begin
			vtx_x[vtx_count] = x;
			vtx_y[vtx_count] = y;
			vtx_z[vtx_count] = z;
			idx = vtx_count;
			vtx_count++;
			placed = 1'b1;
		end
	endtask

	// Works out the result of one edge and updates the shadow tables.
	task automatic predict_edge(input wedt_in_t beat, output wedt_out_t want);
		bit ok_first;
		bit ok_second;
		bit seen;
		int ia;
		int ib;
		int lo;
		int hi;
		want = '0;
		ok_second = 1'b0;
		ib = 0;
		seen = 1'b0;
		find_or_add_vertex(beat.first_x, beat.first_y, beat.first_z, ok_first, ia);
		if (ok_first) begin
			find_or_add_vertex(beat.second_x, beat.second_y, beat.second_z,
					ok_second, ib);
		end
		if (!ok_second) begin
			// A point found no room: no edge work at all.
			want.overflow = 1'b1;
		end else begin
			lo = (ia < ib) ? ia : ib;
			hi = (ia < ib) ? ib : ia;
			want.low_vertex_index  = lo[VIDX_W-1:0];
			want.high_vertex_index = hi[VIDX_W-1:0];
			for (int i = 0; i < edge_count && !seen; i++) begin
				if (edge_lo[i] == lo[VIDX_W-1:0] && edge_hi[i] == hi[VIDX_W-1:0]) begin
					seen = 1'b1;
				end
			end
			if (!seen) begin
				if (edge_count >= MAX_EDGES) begin
					want.overflow = 1'b1;
				end else begin
					edge_lo[edge_count] = lo[VIDX_W-1:0];
					edge_hi[edge_count] = hi[VIDX_W-1:0];
					edge_count++;
					want.edge_was_new = 1'b1;
				end
			end
		end
		want.edge_total   = edge_count[CNT_W-1:0];
		want.vertex_total = vtx_count[CNT_W-1:0];
	endtask

	// Prints one mismatch and counts it.
	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] result beat %0d: %s is %0h, expected %0h",
				$time, beat_no, field, got, want);
		fail_count++;
	endtask

	// Field by field comparison of one result beat.
	task automatic check_result(input wedt_out_t got, input wedt_out_t want);
		if (got.low_vertex_index !== want.low_vertex_index) begin
			report_mismatch("low_vertex_index", got.low_vertex_index,
					want.low_vertex_index);
		end
		if (got.high_vertex_index !== want.high_vertex_index) begin
			report_mismatch("high_vertex_index", got.high_vertex_index,
					want.high_vertex_index);
		end
		if (got.edge_was_new !== want.edge_was_new) begin
			report_mismatch("edge_was_new", got.edge_was_new, want.edge_was_new);
		end
		if (got.edge_total !== want.edge_total) begin
			report_mismatch("edge_total", got.edge_total, want.edge_total);
		end
		if (got.vertex_total !== want.vertex_total) begin
			report_mismatch("vertex_total", got.vertex_total, want.vertex_total);
		end
		if (got.overflow !== want.overflow) begin
			report_mismatch("overflow", got.overflow, want.overflow);
		end
	endtask

	// Predict on each accepted edge, compare on each result strobe.
	always @(posedge clk or negedge arst_n) begin : watch
		wedt_out_t want;
		if (!arst_n) begin
			vtx_count = 0;
			edge_count = 0;
			beat_no = 0;
			owed_results.delete();
		end else begin
			if (start && !busy) begin
				predict_edge(item, want);
				owed_results.push_back(want);
			end
			if (done) begin
				if (owed_results.size() == 0) begin
					report_mismatch("done with no edge outstanding", 1, 0);
				end else begin
					check_result(result, owed_results.pop_front());
				end
				beat_no++;
			end
		end
		pending = owed_results.size();
		vertices_held = vtx_count;
		edges_held = edge_count;
	end

endmodule

@@ test/wireframe_edge_dedup_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wireframe edge dedup table testbench
// Drives directed and random edges into the dedup table, fills the vertex
// and then the edge table to their limits, and leaves all checking to the
// checker that sits beside the block.
// ----------------------------------------------------------------------------

module wireframe_edge_dedup_table_tb;
	import wedt_pkg::*;

	localparam int POOL_DEPTH    = 48;
	localparam int RANDOM_EDGES  = 190;
	localparam int STALL_LIMIT   = 12000;
	localparam int SETTLE_CYCLES = 2 * MAX_VERTICES + MAX_EDGES + 16;

	// Single precision bit patterns used by the directed edges.
	localparam logic [31:0] POS_ZERO   = 32'h0000_0000;
	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF    = 32'hFF80_0000;
	localparam logic [31:0] QNAN       = 32'h7FC0_0000;
	localparam logic [31:0] SNAN_MIN   = 32'h7F80_0001;
	localparam logic [31:0] ONE        = 32'h3F80_0000;
	localparam logic [31:0] ONE_ULP_UP = 32'h3F80_0001;
	localparam logic [31:0] NEG_ONE    = 32'hBF80_0000;
	localparam logic [31:0] TWO        = 32'h4000_0000;
	localparam logic [31:0] HALF       = 32'h3F00_0000;
	localparam logic [31:0] MAX_FINITE = 32'h7F7F_FFFF;
	localparam logic [31:0] MIN_DENORM = 32'h0000_0001;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] ALT_LO     = 32'h5555_5555;
	localparam logic [31:0] ALT_HI     = 32'hAAAA_AAAA;
	localparam logic [31:0] NIB_LO     = 32'h0F0F_0F0F;
	localparam logic [31:0] NIB_HI     = 32'hF0F0_F0F0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	wedt_in_t    item;
	logic        done;
	wedt_out_t   result;

	int          fail_count;
	int          pending;
	int          vertices_held;
	int          edges_held;
	int          gap_pct;
	int          stall_cycles;
	wedt_point_t pool [POOL_DEPTH];
	int          pool_size;

	wireframe_edge_dedup_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	wireframe_edge_dedup_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.done          (done),
		.result        (result),
		.fail_count    (fail_count),
		.pending       (pending),
		.vertices_held (vertices_held),
		.edges_held    (edges_held)
	);

	// Free running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count cycles in which neither an edge nor a result is taken.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog.
	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("wireframe_edge_dedup_table verification failed");
		$finish;
	end

	// One random coordinate, biased toward zeros, infinities, NaNs,
	// denormals and a few common values that collide often.
	function automatic logic [31:0] pick_coord();
		logic [31:0] c;
		case ($urandom_range(9))
			0: c = $urandom & SIGN_BIT;
			1: c = ($urandom & SIGN_BIT) | POS_INF;
			2: begin
				c = $urandom | POS_INF;
				if (c[22:0] == '0) begin
					c[0] = 1'b1;
				end
			end
			3: c = $urandom & 32'h807F_FFFF;
			4, 5, 6: begin
				case ($urandom_range(3))
					0: c = ONE;
					1: c = NEG_ONE;
					2: c = TWO;
					default: c = HALF;
				endcase
			end
			default: c = $urandom;
		endcase
		return c;
	endfunction

	// A zero coordinate comes back with a random sign.
	function automatic logic [31:0] rezero(input logic [31:0] c);
		return (c[30:0] == '0) ? ($urandom & SIGN_BIT) : c;
	endfunction

	// Only finite points go to the pool, so that they always match again.
	function automatic bit finite_point(input wedt_point_t p);
		return (p.x[30:23] != 8'hFF) && (p.y[30:23] != 8'hFF) && (p.z[30:23] != 8'hFF);
	endfunction

	// Either a point sent before or a new one.
	function automatic wedt_point_t random_point();
		wedt_point_t p;
		int roll;
		roll = $urandom_range(99);
		if (pool_size > 0 && roll < 45) begin
			p = pool[$urandom_range(pool_size - 1)];
			p.x = rezero(p.x);
			p.y = rezero(p.y);
			p.z = rezero(p.z);
		end else begin
			if (roll < 90) begin
				p = {pick_coord(), pick_coord(), pick_coord()};
			end else begin
				p = {$urandom, $urandom, $urandom};
			end
			if (pool_size < POOL_DEPTH && finite_point(p)) begin
				pool[pool_size] = p;
				pool_size++;
			end
		end
		return p;
	endfunction

	function automatic wedt_point_t fresh_point();
		return {$urandom, $urandom, $urandom};
	endfunction

	// Sends one edge beat: an optional gap, then start held until taken.
	// Called and returns at a falling edge.
	task automatic send_edge(input wedt_in_t beat);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= beat;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Holds off until every outstanding result has come back.
	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		int i;
		int j;
		int k;
		wedt_point_t pa;
		wedt_point_t pb;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		gap_pct = 8;
		pool_size = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed edges: signed zeros, NaNs, infinities, denormals,
		// ordering, degenerate edges and repeats.
		send_edge({POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO});
		send_edge({SIGN_BIT, POS_ZERO, SIGN_BIT, POS_ZERO, SIGN_BIT, SIGN_BIT});
		send_edge({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
		send_edge({ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
		send_edge({POS_INF, NEG_INF, POS_INF, POS_ZERO, POS_ZERO, POS_ZERO});
		send_edge({SIGN_BIT, SIGN_BIT, POS_ZERO, POS_INF, NEG_INF, POS_INF});
		send_edge({ONE, ONE, ONE, ONE, ONE, ONE});
		send_edge({ONE, ONE, ONE_ULP_UP, ONE, ONE, ONE});
		send_edge({MIN_DENORM, POS_ZERO, POS_ZERO, MIN_DENORM | SIGN_BIT, POS_ZERO,
				POS_ZERO});
		send_edge({QNAN, POS_ZERO, POS_ZERO, POS_INF, NEG_INF, POS_INF});
		send_edge({POS_ZERO, SNAN_MIN, POS_ZERO, ONE, ONE, ONE});
		send_edge({POS_INF, NEG_INF, POS_INF, ONE, ONE, ONE});
		send_edge({ONE, ONE, ONE, POS_INF, NEG_INF, POS_INF});
		send_edge({MAX_FINITE, MAX_FINITE | SIGN_BIT, POS_ZERO,
				MAX_FINITE, MAX_FINITE | SIGN_BIT, SIGN_BIT});
		send_edge({POS_ZERO, SIGN_BIT, POS_ZERO, ONE, ONE, ONE});
		send_edge({ALT_LO, ALT_HI, NIB_LO, ALT_HI, ALT_LO, NIB_HI});
		send_edge({ALT_HI, ALT_LO, NIB_HI, ALT_LO, ALT_HI, NIB_LO});
		wait_idle();

		// Random edges; sender gaps light, then heavy, then none.
		for (i = 0; i < RANDOM_EDGES; i++) begin
			gap_pct = (i < 64) ? 8 : ((i < 128) ? 86 : 0);
			pa = random_point();
			pb = random_point();
			send_edge({pa, pb});
		end
		wait_idle();

		// Fill the vertex table up to one free entry.
		gap_pct = 0;
		while (vertices_held < MAX_VERTICES - 1) begin
			pa = fresh_point();
			pb = (vertices_held < MAX_VERTICES - 2) ? fresh_point() : pool[0];
			send_edge({pa, pb});
		end

		// The first new point takes the last entry and the second overflows;
		// then a new point overflows in either position, a NaN included.
		send_edge({fresh_point(), fresh_point()});
		send_edge({fresh_point(), pool[0]});
		send_edge({pool[0], fresh_point()});
		send_edge({QNAN, POS_ZERO, POS_ZERO, pool[1]});
		wait_idle();

		// Fill the edge table from pairs of known points.
		for (i = 0; i < pool_size && edges_held < MAX_EDGES; i++) begin
			for (j = i; j < pool_size && edges_held < MAX_EDGES; j++) begin
				send_edge({pool[i], pool[j]});
			end
		end

		// Edge table full: unseen pairs overflow, known pairs still match.
		for (k = 0; k < 6 && k + 2 <= pool_size; k++) begin
			send_edge({pool[pool_size - 1 - k], pool[pool_size - 2 - k]});
		end
		send_edge({pool[0], pool[0]});
		gap_pct = 8;
		for (k = 0; k < 20; k++) begin
			pa = random_point();
			pb = random_point();
			send_edge({pa, pb});
		end

		// Drain, then watch for stray result beats.
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("wireframe_edge_dedup_table verification clean");
		end else begin
			$display("wireframe_edge_dedup_table verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/wedt_pkg.sv
hdl/wireframe_edge_dedup_table.sv
test/wireframe_edge_dedup_table_checker.sv
test/wireframe_edge_dedup_table_tb.sv
